// File: design/mtep_pkg.sv
// shared types and constants of the midi track event parser
// used by the parser core and its per-channel state block; no dependencies
package mtep_pkg;

    // parse phases of the track byte stream
    typedef enum logic [3:0] {
        PH_DELTA,
        PH_STATUS,
        PH_ARG1,
        PH_ARG2,
        PH_SX_LEN,
        PH_SX_DATA,
        PH_META_TYPE,
        PH_META_LEN,
        PH_META_DATA,
        PH_ENDED
    } phase_t;

    // event kinds on the result channel
    localparam logic [2:0] KIND_CHANNEL  = 3'd0;
    localparam logic [2:0] KIND_SYSEX    = 3'd1;
    localparam logic [2:0] KIND_TEMPO    = 3'd2;
    localparam logic [2:0] KIND_END      = 3'd3;
    localparam logic [2:0] KIND_SYSTEM   = 3'd4;
    localparam logic [2:0] KIND_NO_STAT  = 3'd5;
    localparam logic [2:0] KIND_META     = 3'd6;

    // channel message opcodes (high nibble of status)
    localparam logic [3:0] OP_NOTE_OFF   = 4'h8;
    localparam logic [3:0] OP_NOTE_ON    = 4'h9;
    localparam logic [3:0] OP_POLY_AT    = 4'ha;
    localparam logic [3:0] OP_CTRL       = 4'hb;
    localparam logic [3:0] OP_PROGRAM    = 4'hc;
    localparam logic [3:0] OP_CHAN_AT    = 4'hd;

    localparam logic [7:0] STATUS_NONE   = 8'h00;
    localparam logic [7:0] STATUS_SYSEX  = 8'hf0;
    localparam logic [7:0] STATUS_META   = 8'hff;

    localparam logic [7:0] META_END      = 8'h2f;
    localparam logic [7:0] META_TEMPO    = 8'h51;

    // controller numbers
    localparam logic [6:0] CC_BANK       = 7'd0;
    localparam logic [6:0] CC_LOOP_MARK  = 7'd2;
    localparam logic [6:0] CC_LOOP_JUMP  = 7'd4;
    localparam logic [6:0] CC_VOLUME     = 7'd7;
    localparam logic [6:0] CC_PAN        = 7'd10;
    localparam logic [6:0] CC_FX1        = 7'd91;
    localparam logic [6:0] CC_FX3        = 7'd93;

    localparam logic [1:0] LOOP_NONE     = 2'd0;
    localparam logic [1:0] LOOP_MARK     = 2'd1;
    localparam logic [1:0] LOOP_JUMP     = 2'd2;

    localparam logic [23:0] TEMPO_DEFAULT = 24'd1000000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_track;
    } track_item_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [7:0]  status_byte;
        logic [6:0]  first_arg;
        logic [6:0]  second_arg;
        logic [7:0]  sysex_value;
        logic [31:0] event_tick;
        logic [23:0] tempo_now;
        logic [6:0]  chan_volume;
        logic        key_now_down;
        logic [1:0]  loop_action;
    } event_item_t;

    typedef struct packed {
        logic [6:0] instrument;
        logic [6:0] bank;
        logic [6:0] volume;
        logic [6:0] pan;
        logic [6:0] fx1;
        logic [6:0] fx3;
    } chan_settings_t;

    // channel message handed to the per-channel state block
    typedef struct packed {
        logic       upd;
        logic [3:0] chan;
        logic [3:0] op;
        logic [6:0] a1;
        logic [6:0] a2;
    } chan_req_t;

    typedef struct packed {
        logic       key_now_down;
        logic [6:0] chan_volume;
    } chan_rsp_t;

endpackage

// File: design/mtep_stream_if.sv
// valid/ready stream channel used on both sides of the parser
// payload type is set per instance; no dependencies
interface mtep_stream_if #(parameter type payload_t = logic [7:0]);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: design/mtep_chan_state.sv
// per-channel key bits and controller settings of the midi track event parser
// depends on mtep_pkg
module mtep_chan_state
    import mtep_pkg::*;
#(
    parameter int CHANNELS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  chan_req_t req,
    output chan_rsp_t rsp
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [127:0]   key_bits_reg [CHANNELS];
    chan_settings_t settings_reg [CHANNELS];

    logic           ok;
    logic [CH_W-1:0] idx;
    logic [127:0]   row;
    logic [127:0]   row_next;
    logic           key_new;
    chan_settings_t set_cur;
    chan_settings_t set_next;

    always_comb
    begin
        ok       = ({1'b0, req.chan} < 5'(CHANNELS));
        idx      = req.chan[CH_W-1:0];
        row      = key_bits_reg[idx];
        set_cur  = settings_reg[idx];
        key_new  = row[req.a1];
        if (req.op == OP_NOTE_ON && req.a2 != 7'd0)
        begin
            key_new = 1'b1;
        end
        else if (req.op == OP_NOTE_ON || req.op == OP_NOTE_OFF)
        begin
            key_new = 1'b0;
        end
        row_next          = row;
        row_next[req.a1]  = key_new;

        set_next = set_cur;
        if (req.op == OP_PROGRAM)
        begin
            set_next.instrument = req.a1;
        end
        else if (req.op == OP_CTRL)
        begin
            case (req.a1)
                CC_BANK:   set_next.bank   = req.a2;
                CC_VOLUME: set_next.volume = req.a2;
                CC_FX1:    set_next.fx1    = req.a2;
                CC_FX3:    set_next.fx3    = req.a2;
                CC_PAN:    set_next.pan    = req.a2;
                default:   set_next        = set_cur;
            endcase
        end

        rsp.key_now_down = ok && key_new &&
                           (req.op == OP_NOTE_OFF || req.op == OP_NOTE_ON ||
                            req.op == OP_POLY_AT);
        rsp.chan_volume  = ok ? set_next.volume : 7'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                key_bits_reg[i] <= '0;
                settings_reg[i] <= '0;
            end
        end
        else if (req.upd && ok)
        begin
            key_bits_reg[idx] <= row_next;
            settings_reg[idx] <= set_next;
        end
    end

endmodule

// File: design/midi_track_event_parser_core.sv
// top level of the midi track event parser: byte-serial track decoding
// depends on mtep_pkg, mtep_stream_if and mtep_chan_state
//
// usage
//   track  : sink channel, one raw track byte per transfer (data_byte) plus
//            start_of_track, which clears running status, tick and delta sum
//            before the byte is read as the start of a delta time
//   events : source channel, at most one event per track byte: channel
//            messages, sysex payload bytes, tempo set, end of track, lone
//            system bytes, meta done and the no-status error
// path: a byte's transfer fills the input register, then its event is
//   decoded into the result register
// throughput: one byte per cycle unless an event byte waits on a full result
//   register; all decoding of a byte is one pass of logic between the input
//   register and the result register, and the parse state is updated in the same cycle
// stalls: bytes that make no event keep flowing while a result waits; a
//   byte that makes an event waits in the input register until the
//   result register is free, and track.ready stays low meanwhile
// reset: parse state, key bits and channel settings are cleared at once and
//   tempo is set to 1000000 us per quarter; track.ready is high as soon as
//   reset is released
// after end of track every byte is swallowed until start_of_track
module midi_track_event_parser_core
    import mtep_pkg::*;
#(
    parameter int CHANNELS  = 16,
    parameter int TICK_BITS = 32
)
(
    input logic          clk,
    input logic          rst_n,
    mtep_stream_if.sink   track,
    mtep_stream_if.source events
);

    // tick sum is at least as wide as a delta, so wraps follow TICK_BITS
    localparam int SUM_W = (TICK_BITS > 32) ? TICK_BITS : 32;

    // input register
    logic        in_valid_reg;
    track_item_t item_reg;

    // result register
    logic        out_valid_reg;
    event_item_t result_reg;

    // parse state
    phase_t               phase_reg,  phase_next;
    logic [7:0]           running_status_reg, running_status_next;
    logic [31:0]          vlq_reg,    vlq_next;
    logic [TICK_BITS-1:0] tick_reg,   tick_next;
    logic [7:0]           meta_type_reg, meta_type_next;
    logic [31:0]          bytes_left_reg, bytes_left_next;
    logic [23:0]          tempo_reg,  tempo_next;
    logic [6:0]           held_arg_reg, held_arg_next;

    // decode
    logic [7:0]           b;
    phase_t               cur_phase;
    logic [7:0]           cur_status;
    logic [31:0]          cur_vlq;
    logic [TICK_BITS-1:0] cur_tick;
    logic [31:0]          vlq_shift;
    logic [SUM_W-1:0]     tick_sum;
    logic [SUM_W-1:0]     tick_ext;
    logic [31:0]          bytes_dec;
    logic                 has_result;
    logic                 do_chan;
    logic                 meta_end;
    logic [7:0]           chan_status;
    logic [6:0]           a1;
    logic [6:0]           a2;
    logic [2:0]           res_kind;
    logic [7:0]           res_status;
    logic [7:0]           res_sysex;
    event_item_t          res;
    chan_req_t            chan_req;
    chan_rsp_t            chan_rsp;
    logic                 out_free;
    logic                 fire;

    assign b = item_reg.data_byte;

    // start_of_track clears running status, tick and accumulator first and restarts at the delta phase
    always_comb
    begin
        cur_phase  = item_reg.start_of_track ? PH_DELTA : phase_reg;
        cur_status = item_reg.start_of_track ? STATUS_NONE : running_status_reg;
        cur_vlq    = item_reg.start_of_track ? 32'd0 : vlq_reg;
        cur_tick   = item_reg.start_of_track ? '0 : tick_reg;
        vlq_shift  = {cur_vlq[24:0], b[6:0]};
        tick_sum   = SUM_W'(cur_tick) + SUM_W'(vlq_shift);
        tick_ext   = SUM_W'(cur_tick);
        bytes_dec  = bytes_left_reg - 32'd1;
    end

    // next state of the parser
    always_comb
    begin
        phase_next          = cur_phase;
        running_status_next = cur_status;
        vlq_next            = cur_vlq;
        tick_next           = cur_tick;
        meta_type_next      = meta_type_reg;
        bytes_left_next     = bytes_left_reg;
        tempo_next          = tempo_reg;
        held_arg_next       = held_arg_reg;
        has_result          = 1'b0;
        do_chan             = 1'b0;
        meta_end            = 1'b0;
        chan_status         = cur_status;
        a1                  = b[6:0];
        a2                  = 7'd0;
        res_kind            = KIND_CHANNEL;
        res_status          = STATUS_NONE;
        res_sysex           = 8'd0;

        unique case (cur_phase)
            PH_DELTA:
            begin
                vlq_next = vlq_shift;
                if (!b[7])
                begin
                    tick_next  = tick_sum[TICK_BITS-1:0];
                    vlq_next   = 32'd0;
                    phase_next = PH_STATUS;
                end
            end
            PH_STATUS:
            begin
                if (!b[7])
                begin
                    // data byte: running status
                    if (cur_status == STATUS_NONE)
                    begin
                        phase_next = PH_DELTA;
                        has_result = 1'b1;
                        res_kind   = KIND_NO_STAT;
                    end
                    else if (cur_status[7:4] == OP_PROGRAM ||
                             cur_status[7:4] == OP_CHAN_AT)
                    begin
                        do_chan = 1'b1;
                    end
                    else
                    begin
                        held_arg_next = b[6:0];
                        phase_next    = PH_ARG2;
                    end
                end
                else if (b < STATUS_SYSEX)
                begin
                    running_status_next = b;
                    phase_next          = PH_ARG1;
                end
                else
                begin
                    // system statuses cancel running status
                    running_status_next = STATUS_NONE;
                    vlq_next            = 32'd0;
                    if (b == STATUS_SYSEX)
                    begin
                        phase_next = PH_SX_LEN;
                    end
                    else if (b == STATUS_META)
                    begin
                        phase_next = PH_META_TYPE;
                    end
                    else
                    begin
                        phase_next = PH_DELTA;
                        has_result = 1'b1;
                        res_kind   = KIND_SYSTEM;
                        res_status = b;
                    end
                end
            end
            PH_ARG1:
            begin
                if (cur_status[7:4] == OP_PROGRAM || cur_status[7:4] == OP_CHAN_AT)
                begin
                    do_chan = 1'b1;
                end
                else
                begin
                    held_arg_next = b[6:0];
                    phase_next    = PH_ARG2;
                end
            end
            PH_ARG2:
            begin
                do_chan = 1'b1;
                a1      = held_arg_reg;
                a2      = b[6:0];
            end
            PH_SX_LEN:
            begin
                vlq_next = vlq_shift;
                if (!b[7])
                begin
                    bytes_left_next = vlq_shift;
                    vlq_next        = 32'd0;
                    phase_next      = (vlq_shift != 32'd0) ? PH_SX_DATA : PH_DELTA;
                end
            end
            PH_SX_DATA:
            begin
                bytes_left_next = bytes_dec;
                if (bytes_dec == 32'd0)
                begin
                    phase_next = PH_DELTA;
                end
                has_result = 1'b1;
                res_kind   = KIND_SYSEX;
                res_status = STATUS_SYSEX;
                res_sysex  = b;
            end
            PH_META_TYPE:
            begin
                meta_type_next = b;
                vlq_next       = 32'd0;
                phase_next     = PH_META_LEN;
            end
            PH_META_LEN:
            begin
                vlq_next = vlq_shift;
                if (!b[7])
                begin
                    bytes_left_next = vlq_shift;
                    vlq_next        = 32'd0;
                    if (meta_type_reg == META_TEMPO)
                    begin
                        tempo_next = 24'd0;
                    end
                    if (vlq_shift == 32'd0 || meta_type_reg == META_END)
                    begin
                        meta_end = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_META_DATA;
                    end
                end
            end
            PH_META_DATA:
            begin
                if (meta_type_reg == META_TEMPO)
                begin
                    // big-endian, the last three bytes stay
                    tempo_next = {tempo_reg[15:0], b};
                end
                bytes_left_next = bytes_dec;
                if (bytes_dec == 32'd0)
                begin
                    meta_end = 1'b1;
                end
            end
            PH_ENDED:
            begin
                phase_next = PH_ENDED;
            end
            default:
            begin
                phase_next = cur_phase;
            end
        endcase

        if (meta_end)
        begin
            has_result = 1'b1;
            res_status = STATUS_META;
            if (meta_type_reg == META_END)
            begin
                phase_next = PH_ENDED;
                res_kind   = KIND_END;
            end
            else
            begin
                phase_next = PH_DELTA;
                res_kind   = (meta_type_reg == META_TEMPO) ? KIND_TEMPO : KIND_META;
            end
        end

        if (do_chan)
        begin
            has_result = 1'b1;
            phase_next = PH_DELTA;
            res_kind   = KIND_CHANNEL;
            res_status = chan_status;
        end
    end

    // per-channel state sees the message only when the byte is consumed
    always_comb
    begin
        chan_req.upd  = do_chan && fire;
        chan_req.chan = chan_status[3:0];
        chan_req.op   = chan_status[7:4];
        chan_req.a1   = a1;
        chan_req.a2   = a2;
    end

    mtep_chan_state #(
        .CHANNELS (CHANNELS)
    ) u_chan_state (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (chan_req),
        .rsp   (chan_rsp)
    );

    // result fields
    always_comb
    begin
        res              = '0;
        res.event_kind   = res_kind;
        res.status_byte  = res_status;
        res.sysex_value  = res_sysex;
        res.event_tick   = tick_ext[31:0];
        res.tempo_now    = tempo_next;
        if (do_chan)
        begin
            res.first_arg    = a1;
            res.second_arg   = a2;
            res.chan_volume  = chan_rsp.chan_volume;
            res.key_now_down = chan_rsp.key_now_down;
            if (chan_status[7:4] == OP_CTRL && a1 == CC_LOOP_MARK)
            begin
                res.loop_action = LOOP_MARK;
            end
            else if (chan_status[7:4] == OP_CTRL && a1 == CC_LOOP_JUMP)
            begin
                res.loop_action = LOOP_JUMP;
            end
            else
            begin
                res.loop_action = LOOP_NONE;
            end
        end
    end

    // handshake: bytes without an event never wait on the result side
    assign out_free       = !out_valid_reg || events.ready;
    assign fire           = in_valid_reg && (!has_result || out_free);
    assign track.ready    = !in_valid_reg || fire;
    assign events.valid   = out_valid_reg;
    assign events.payload = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            phase_reg          <= PH_DELTA;
            running_status_reg <= STATUS_NONE;
            vlq_reg            <= 32'd0;
            tick_reg           <= '0;
            meta_type_reg      <= 8'd0;
            bytes_left_reg     <= 32'd0;
            tempo_reg          <= TEMPO_DEFAULT;
            held_arg_reg       <= 7'd0;
        end
        else
        begin
            if (track.valid && track.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (fire && has_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (events.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                phase_reg          <= phase_next;
                running_status_reg <= running_status_next;
                vlq_reg            <= vlq_next;
                tick_reg           <= tick_next;
                meta_type_reg      <= meta_type_next;
                bytes_left_reg     <= bytes_left_next;
                tempo_reg          <= tempo_next;
                held_arg_reg       <= held_arg_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (track.valid && track.ready)
        begin
            item_reg <= track.payload;
        end
        if (fire && has_result)
        begin
            result_reg <= res;
        end
    end

`ifndef SYNTHESIS
    // a byte is only refused while one is waiting in the input register
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !track.ready |-> in_valid_reg)
        else $error("track refused with empty input register");

    // argument phases always run under a channel status
    a_args_have_status: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ARG1 || phase_reg == PH_ARG2) |-> running_status_reg[7])
        else $error("argument phase without channel status");

    // payload phases never start with an exhausted count
    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SX_DATA || phase_reg == PH_META_DATA) |->
            bytes_left_reg != 32'd0)
        else $error("payload phase with zero bytes left");

    // a stalled result is never overwritten
    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !events.ready |=> out_valid_reg && $stable(result_reg))
        else $error("pending result lost or changed");
`endif

endmodule
